### src/shortest_path_count_max_weight_assert.svh
// Assertion macros for the shortest path counter.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef SHORTEST_PATH_COUNT_MAX_WEIGHT_ASSERT_SVH
`define SHORTEST_PATH_COUNT_MAX_WEIGHT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SPCMW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SPCMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/spcmw_pkg.sv
// Shared constants and control types for the shortest path counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spcmw_pkg;
  localparam int MAX_NODES_DEF = 64;
  localparam int DIST_W = 32;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 24;
  localparam int NW_W   = 10;
  localparam int COST_W = 16;
  localparam int ADJ_W  = COST_W + 1;
  localparam int NODE_W = 6;
  localparam int NCNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 2'd2;

  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic clr;
    logic accept;
    logic init0;
    logic init1;
    logic sel;
    logic pick;
    logic loadu;
    logic relax;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic drained;
    logic found;
    logic out_free;
  } status_t;
endpackage
`default_nettype wire

### src/spcmw_if.sv
// Handshake interfaces for input words and result words.
// Depends on spcmw_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface spcmw_item_if import spcmw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  logic [COST_W-1:0] edge_cost;
  logic [NW_W-1:0]   node_weight;
  modport source (output valid, opcode, node_a, node_b, edge_cost, node_weight, input ready);
  modport sink (input valid, opcode, node_a, node_b, edge_cost, node_weight, output ready);
endinterface

interface spcmw_result_if import spcmw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] path_count;
  logic [SUM_W-1:0] best_weight;
  modport source (output valid, path_count, best_weight, input ready);
  modport sink (input valid, path_count, best_weight, output ready);
endinterface
`default_nettype wire

### src/spcmw_datapath.sv
// Datapath: edge and node stores, per-node search state, scan and output register.
// Depends on spcmw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spcmw_datapath import spcmw_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    stat,
  input  wire logic [1:0]            opcode,
  input  wire logic [NODE_W-1:0]     node_a,
  input  wire logic [NODE_W-1:0]     node_b,
  input  wire logic [COST_W-1:0]     edge_cost,
  input  wire logic [NW_W-1:0]       node_weight,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CNT_W-1:0]           path_count,
  output logic [SUM_W-1:0]           best_weight
);
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int AW = 2 * IW;
  localparam int ADEPTH = 1 << AW;

  logic [NCNT_W-1:0] node_count;
  logic [NODE_W-1:0] source_node, target_node;
  logic [CW-1:0] n_use;
  logic [IW-1:0] src_idx, tgt_idx, a_idx, b_idx;
  logic a_ok, b_ok, ld_w, ld_e;
  logic [AW-1:0] e_addr, r_addr, clr_cnt;
  logic [ADJ_W-1:0] adj_mem [ADEPTH];
  logic [ADJ_W-1:0] adj_q;
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic [CNT_W-1:0]  cnt_mem [MAX_NODES];
  logic [SUM_W-1:0]  sum_mem [MAX_NODES];
  logic [NW_W-1:0]   nw_mem [MAX_NODES];
  logic [DIST_W-1:0] dist_q, dmin, nd_u, wr_dist;
  logic [CNT_W-1:0]  cnt_q, cu, cnt_add, wr_cnt;
  logic [SUM_W-1:0]  sum_q, su, nws, wr_sum;
  logic [NW_W-1:0]   nw_q;
  logic [CNT_W:0]    cnt_wide;
  logic [SUM_W:0]    sum_wide;
  logic [MAX_NODES-1:0] reached, done;
  logic [CW-1:0] scan;
  logic scan_vld, issue, drained, found, sel_cand;
  logic [IW-1:0] scan_idx, scan_d, u, cs_ra, nw_ra, hi, lo;
  logic rl_new, rl_eq, rl_wr, wr_en;
  logic [IW-1:0] wr_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      source_node <= '0;
      target_node <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count  <= cfg_data;
        REG_SOURCE:     source_node <= cfg_data[NODE_W-1:0];
        REG_TARGET:     target_node <= cfg_data[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_use = (32'(node_count) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count);
  assign src_idx = IW'(source_node);
  assign tgt_idx = IW'(target_node);
  assign stat.bad = (32'(source_node) >= 32'(n_use)) || (32'(target_node) >= 32'(n_use));

  // Load decode
  assign a_idx = IW'(node_a);
  assign b_idx = IW'(node_b);
  assign a_ok = 32'(node_a) < 32'(MAX_NODES);
  assign b_ok = 32'(node_b) < 32'(MAX_NODES);
  assign ld_w = cmd.accept && (opcode == OP_WEIGHT) && a_ok;
  assign ld_e = cmd.accept && (opcode == OP_EDGE) && a_ok && b_ok;
  // store each undirected edge once, keyed by the ordered pair
  assign e_addr = (a_idx > b_idx) ? {a_idx, b_idx} : {b_idx, a_idx};

  // Clearing pass over the edge store after reset
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
  end
  assign stat.clr_last = (clr_cnt == {AW{1'b1}});

  // Scan counter shared by the select and relax passes; hold at the end
  // of a pass until the last read drains, then rewind
  assign scan_idx = scan[IW-1:0];
  assign issue    = (cmd.sel || cmd.relax) && (scan < n_use);
  assign drained  = (scan == n_use) && !scan_vld;
  assign stat.drained = drained;
  always_ff @(posedge clk) begin
    if (rst) begin
      scan     <= '0;
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= issue;
      if (issue) scan <= scan + 1'b1;
      else if (drained || !(cmd.sel || cmd.relax)) scan <= '0;
    end
  end
  always_ff @(posedge clk) scan_d <= scan_idx;

  // Edge store
  assign hi = (u > scan_idx) ? u : scan_idx;
  assign lo = (u > scan_idx) ? scan_idx : u;
  assign r_addr = {hi, lo};
  always_ff @(posedge clk) begin
    if (cmd.clr) adj_mem[clr_cnt] <= '0;
    else if (ld_e) adj_mem[e_addr] <= {1'b1, edge_cost};
    adj_q <= adj_mem[r_addr];
  end

  // Node weight store
  assign nw_ra = cmd.init0 ? src_idx : scan_idx;
  always_ff @(posedge clk) begin
    if (ld_w) nw_mem[a_idx] <= node_weight;
    nw_q <= nw_mem[nw_ra];
  end

  // Relaxation of one neighbor from registered reads
  assign sum_wide = (SUM_W+1)'(su) + (SUM_W+1)'(nw_q);
  assign nws = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign cnt_wide = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(cu);
  assign cnt_add = cnt_wide[CNT_W] ? {CNT_W{1'b1}} : cnt_wide[CNT_W-1:0];
  assign nd_u = dmin + DIST_W'(adj_q[COST_W-1:0]);
  assign rl_new = !reached[scan_d] || (nd_u < dist_q);
  assign rl_eq  = (nd_u == dist_q);
  assign rl_wr  = cmd.relax && scan_vld && !done[scan_d] && adj_q[COST_W] && (rl_new || rl_eq);

  // Write-back mux: seed the source, or update a relaxed neighbor
  always_comb begin
    wr_en   = cmd.init1 || rl_wr;
    wr_addr = cmd.init1 ? src_idx : scan_d;
    wr_dist = '0;
    wr_cnt  = CNT_W'(1);
    wr_sum  = SUM_W'(nw_q);
    if (!cmd.init1) begin
      if (rl_new) begin
        wr_dist = nd_u;
        wr_cnt  = cu;
        wr_sum  = nws;
      end else begin
        wr_dist = dist_q;
        wr_cnt  = cnt_add;
        wr_sum  = (nws > sum_q) ? nws : sum_q;
      end
    end
  end

  assign cs_ra = cmd.relax ? scan_idx : (cmd.pick ? u : tgt_idx);
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_dist;
      cnt_mem[wr_addr]  <= wr_cnt;
      sum_mem[wr_addr]  <= wr_sum;
    end
    dist_q <= dist_mem[scan_idx];
    cnt_q  <= cnt_mem[cs_ra];
    sum_q  <= sum_mem[cs_ra];
  end

  // Reached and finished marks
  always_ff @(posedge clk) begin
    if (rst || cmd.init0) begin
      reached <= '0;
      done    <= '0;
    end else begin
      if (cmd.init1) reached[src_idx] <= 1'b1;
      if (rl_wr) reached[scan_d] <= 1'b1;
      if (cmd.pick) done[u] <= 1'b1;
    end
  end

  // Minimum search; strict compare keeps the lowest index on a tie
  assign sel_cand = cmd.sel && scan_vld && !done[scan_d] && reached[scan_d] &&
                    (!found || (dist_q < dmin));
  always_ff @(posedge clk) begin
    if (rst || cmd.init1 || cmd.relax) found <= 1'b0;
    else if (sel_cand) found <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (sel_cand) begin
      u    <= scan_d;
      dmin <= dist_q;
    end
    if (cmd.loadu) begin
      cu <= cnt_q;
      su <= sum_q;
    end
  end
  assign stat.found = found;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_zero || !reached[tgt_idx]) begin
        path_count  <= '0;
        best_weight <= '0;
      end else begin
        path_count  <= cnt_q;
        best_weight <= sum_q;
      end
    end
  end
  assign stat.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

### src/spcmw_ctrl.sv
// Controller: sequences clearing, loads and the search passes.
// Depends on spcmw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spcmw_ctrl import spcmw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] opcode,
  output logic            in_ready,
  output cmd_t            cmd,
  input  wire status_t    stat
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT0 = 4'd2;
  localparam logic [3:0] S_INIT1 = 4'd3;
  localparam logic [3:0] S_SEL   = 4'd4;
  localparam logic [3:0] S_PICK  = 4'd5;
  localparam logic [3:0] S_LOADU = 4'd6;
  localparam logic [3:0] S_RELAX = 4'd7;
  localparam logic [3:0] S_TGT   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state, state_next;
  logic zero_flag, zero_flag_next;
  logic start;

  assign in_ready = (state == S_IDLE);
  assign start = in_valid && in_ready && (opcode == OP_START);

  // Next state and commands
  always_comb begin
    state_next     = state;
    zero_flag_next = zero_flag;
    cmd            = '0;
    cmd.accept     = in_valid && in_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          zero_flag_next = stat.bad;
          state_next = stat.bad ? S_TGT : S_INIT0;
        end
      end
      S_INIT0: begin
        cmd.init0 = 1'b1;
        state_next = S_INIT1;
      end
      S_INIT1: begin
        cmd.init1 = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        if (stat.drained) state_next = S_PICK;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd.pick = 1'b1;
          state_next = S_LOADU;
        end else begin
          state_next = S_TGT;
        end
      end
      S_LOADU: begin
        cmd.loadu = 1'b1;
        state_next = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax = 1'b1;
        if (stat.drained) state_next = S_SEL;
      end
      S_TGT: state_next = S_OUT;
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = zero_flag;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      zero_flag <= 1'b0;
    end else begin
      state     <= state_next;
      zero_flag <= zero_flag_next;
    end
  end
endmodule
`default_nettype wire

### src/shortest_path_count_max_weight.sv
// Top level of the shortest path counter: controller plus datapath.
// Depends on spcmw_pkg, spcmw_if, spcmw_ctrl, spcmw_datapath and the assertion header.
//
//   port        dir   words
//   item        in    load weight, load edge, start search
//   result      out   path count and best weight, one per start
//   cfg_*       in    node_count, source_node, target_node writes
//
// A load word is taken while the block is idle. A start word holds the block
// until the search ends: each finished node costs one scan of the distance
// store to pick the minimum and one scan of its edge row. A start with a bad
// setup skips the search and gives a zero result.
// After reset the edge store is swept, one entry a cycle, before any word is taken.
// A stalled result holds in its register; new words are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "shortest_path_count_max_weight_assert.svh"
module shortest_path_count_max_weight import spcmw_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  spcmw_item_if.sink                 item,
  spcmw_result_if.source             result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  cmd_t    cmd;
  status_t stat;
  logic    start_taken;

  spcmw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .opcode   (item.opcode),
    .in_ready (item.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  spcmw_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (item.opcode),
    .node_a      (item.node_a),
    .node_b      (item.node_b),
    .edge_cost   (item.edge_cost),
    .node_weight (item.node_weight),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .path_count  (result.path_count),
    .best_weight (result.best_weight)
  );

  // Assertions
  assign start_taken = item.valid && item.ready && (item.opcode == OP_START);
  `SPCMW_ASSERT_NOW(a_clear_blocks, cmd.clr, !item.ready, "input taken during clearing")
  `SPCMW_ASSERT_NEXT(a_start_busy, start_taken, !item.ready, "block idle after start")
  `SPCMW_ASSERT_NOW(a_result_source, $rose(result.valid), $past(cmd.out_load), "stray result")
endmodule
`default_nettype wire
